// ===== rtl/rdz_pkg.sv =====
// ----------------------------------------------------------------------------
// Radial deadzone scaler package
// Zone codes, register indexes, stage counts and the pipeline sample type.
// ----------------------------------------------------------------------------
package rdz_pkg;

   localparam int SQ_STAGES  = 16;
   localparam int DIV_STAGES = 15;

   localparam logic [1:0] ZONE_DEAD = 2'd0;
   localparam logic [1:0] ZONE_BAND = 2'd1;
   localparam logic [1:0] ZONE_PASS = 2'd2;

   localparam logic [1:0] CSR_DEAD_RADIUS  = 2'd0;
   localparam logic [1:0] CSR_OUTER_RADIUS = 2'd1;

   typedef struct packed {
      logic [15:0] y;
      logic [15:0] x;
   } sample_type;

endpackage

// ===== rtl/radial_deadzone_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// Radial deadzone scaler
// Maps a stick sample through a scaled radial deadzone with a pipelined
// square root and two pipelined restoring divider sections.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// req      in         tdata: in_x, in_y
// rsp      out        tdata: out_x, out_y; tuser: zone
// csr      in         index, data (register write, always ready)
//
// One sample is taken every cycle while the pipeline advances; it holds an entry stage,
// 16 square root stages, two 16-stage divider sections and an output register.
// The whole pipeline advances whenever the output register is empty or its
// transfer completes, so a stall holds every stage in place.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module radial_deadzone_scaler_unit
   import rdz_pkg::*;
#(
   parameter int AXIS_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // in_x [15:0], in_y [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_x [15:0], out_y [31:16]
   output logic [1:0]  rsp_tuser,   // zone [1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);

   localparam int AXIS_MAX = (1 << (AXIS_WIDTH - 1)) - 1;
   localparam logic signed [16:0] AXIS_HI = 17'(AXIS_MAX);
   localparam logic signed [16:0] AXIS_LO = 17'(-AXIS_MAX - 1);

   function automatic logic [16:0] div_step(input logic [15:0] rem, input logic nb,
                                            input logic [15:0] den);
      logic [16:0] t;
      logic [16:0] d;
      t = {rem, nb};
      d = {1'b0, den};
      if (t >= d) begin
         div_step = {1'b1, 16'(t - d)};
      end else begin
         div_step = {1'b0, t[15:0]};
      end
   endfunction

   function automatic logic [15:0] sat_axis(input logic signed [16:0] v);
      if (v > AXIS_HI) begin
         sat_axis = AXIS_HI[15:0];
      end else if (v < AXIS_LO) begin
         sat_axis = AXIS_LO[15:0];
      end else begin
         sat_axis = v[15:0];
      end
   endfunction

   function automatic logic [15:0] abs16(input logic [15:0] a);
      logic [16:0] e;
      e = {a[15], a};
      abs16 = a[15] ? 16'(~e + 17'd1) : a;
   endfunction

   logic        adv;
   logic [14:0] dead_ff;
   logic [14:0] outer_ff;

   // Square root section.
   logic        sq_v_ff    [0:SQ_STAGES];
   logic [31:0] sq_rem_ff  [0:SQ_STAGES];
   logic [31:0] sq_root_ff [0:SQ_STAGES];
   sample_type  sq_s_ff    [0:SQ_STAGES];
   logic [31:0] sq_rem_in  [0:SQ_STAGES];
   logic [31:0] sq_root_in [0:SQ_STAGES];

   // Output radius divider section.
   logic        d1_v_ff    [0:DIV_STAGES];
   logic [30:0] d1_num_ff  [0:DIV_STAGES];
   logic [15:0] d1_rem_ff  [0:DIV_STAGES];
   logic [15:0] d1_den_ff  [0:DIV_STAGES];
   logic [14:0] d1_q_ff    [0:DIV_STAGES];
   logic [15:0] d1_r_ff    [0:DIV_STAGES];
   logic [1:0]  d1_zone_ff [0:DIV_STAGES];
   sample_type  d1_s_ff    [0:DIV_STAGES];
   logic [15:0] d1_rem_in  [0:DIV_STAGES];
   logic [14:0] d1_q_in    [0:DIV_STAGES];

   // Axis scaling divider section.
   logic        d2_v_ff    [0:DIV_STAGES];
   logic [30:0] d2_nx_ff   [0:DIV_STAGES];
   logic [30:0] d2_ny_ff   [0:DIV_STAGES];
   logic [15:0] d2_rx_ff   [0:DIV_STAGES];
   logic [15:0] d2_ry_ff   [0:DIV_STAGES];
   logic [14:0] d2_qx_ff   [0:DIV_STAGES];
   logic [14:0] d2_qy_ff   [0:DIV_STAGES];
   logic [15:0] d2_den_ff  [0:DIV_STAGES];
   logic [1:0]  d2_zone_ff [0:DIV_STAGES];
   sample_type  d2_s_ff    [0:DIV_STAGES];
   logic [15:0] d2_rx_in   [0:DIV_STAGES];
   logic [15:0] d2_ry_in   [0:DIV_STAGES];
   logic [14:0] d2_qx_in   [0:DIV_STAGES];
   logic [14:0] d2_qy_in   [0:DIV_STAGES];

   logic        out_v_ff;
   logic [31:0] out_data_ff;
   logic [1:0]  out_zone_ff;
   logic [31:0] out_data_in;

   logic signed [15:0] in_x;
   logic signed [15:0] in_y;
   logic [15:0] root;
   logic [1:0]  zone_in;
   logic [14:0] diff;
   logic [29:0] band_num;
   logic [14:0] r_out;
   logic [15:0] mag_x;
   logic [15:0] mag_y;
   logic [30:0] prod_x;
   logic [30:0] prod_y;

   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_zone_ff;

   assign in_x = req_tdata[15:0];
   assign in_y = req_tdata[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_ff  <= '0;
         outer_ff <= 15'h7fff;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEAD_RADIUS:  dead_ff  <= csr_data;
            CSR_OUTER_RADIUS: outer_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Square root: one result bit per stage.
   always_comb begin
      sq_rem_in[0]  = 32'(in_x) * 32'(in_x) + 32'(in_y) * 32'(in_y);
      sq_root_in[0] = '0;
      for (int i = 1; i <= SQ_STAGES; i++) begin
         if (sq_rem_ff[i-1] >= sq_root_ff[i-1] + (32'd1 << (2 * (SQ_STAGES - i)))) begin
            sq_rem_in[i]  = sq_rem_ff[i-1] - (sq_root_ff[i-1] +
                            (32'd1 << (2 * (SQ_STAGES - i))));
            sq_root_in[i] = (sq_root_ff[i-1] >> 1) + (32'd1 << (2 * (SQ_STAGES - i)));
         end else begin
            sq_rem_in[i]  = sq_rem_ff[i-1];
            sq_root_in[i] = sq_root_ff[i-1] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= sq_rem_in[0];
         sq_root_ff[0] <= sq_root_in[0];
         sq_s_ff[0]    <= req_tdata;
         for (int i = 1; i <= SQ_STAGES; i++) begin
            sq_rem_ff[i]  <= sq_rem_in[i];
            sq_root_ff[i] <= sq_root_in[i];
            sq_s_ff[i]    <= sq_s_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= SQ_STAGES; i++) begin
            sq_v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         sq_v_ff[0] <= req_tvalid;
         for (int i = 1; i <= SQ_STAGES; i++) begin
            sq_v_ff[i] <= sq_v_ff[i-1];
         end
      end
   end

   // Zone decision and output radius division.
   always_comb begin
      root     = sq_root_ff[SQ_STAGES][15:0];
      diff     = 15'(root - {1'b0, dead_ff});
      band_num = diff * outer_ff;
      if (dead_ff == '0) begin
         zone_in = ZONE_PASS;
      end else if (root < {1'b0, dead_ff}) begin
         zone_in = ZONE_DEAD;
      end else if (root < {1'b0, outer_ff}) begin
         zone_in = ZONE_BAND;
      end else begin
         zone_in = ZONE_PASS;
      end
      d1_rem_in[0] = '0;
      d1_q_in[0]   = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         {d1_q_in[k][0], d1_rem_in[k]} = div_step(d1_rem_ff[k-1],
                                                  d1_num_ff[k-1][DIV_STAGES-k],
                                                  d1_den_ff[k-1]);
         d1_q_in[k][14:1] = d1_q_ff[k-1][13:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_num_ff[0]  <= {1'b0, band_num};
         d1_rem_ff[0]  <= {1'b0, band_num[29:15]};
         d1_den_ff[0]  <= {1'b0, 15'(outer_ff - dead_ff)};
         d1_q_ff[0]    <= '0;
         d1_r_ff[0]    <= root;
         d1_zone_ff[0] <= zone_in;
         d1_s_ff[0]    <= sq_s_ff[SQ_STAGES];
         for (int k = 1; k <= DIV_STAGES; k++) begin
            d1_num_ff[k]  <= d1_num_ff[k-1];
            d1_rem_ff[k]  <= d1_rem_in[k];
            d1_den_ff[k]  <= d1_den_ff[k-1];
            d1_q_ff[k]    <= d1_q_in[k];
            d1_r_ff[k]    <= d1_r_ff[k-1];
            d1_zone_ff[k] <= d1_zone_ff[k-1];
            d1_s_ff[k]    <= d1_s_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            d1_v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         d1_v_ff[0] <= sq_v_ff[SQ_STAGES];
         for (int k = 1; k <= DIV_STAGES; k++) begin
            d1_v_ff[k] <= d1_v_ff[k-1];
         end
      end
   end

   // Axis scaling: magnitude times output radius over input radius.
   always_comb begin
      r_out  = d1_q_ff[DIV_STAGES];
      mag_x  = abs16(d1_s_ff[DIV_STAGES].x);
      mag_y  = abs16(d1_s_ff[DIV_STAGES].y);
      prod_x = mag_x * r_out;
      prod_y = mag_y * r_out;
      d2_rx_in[0] = '0;
      d2_ry_in[0] = '0;
      d2_qx_in[0] = '0;
      d2_qy_in[0] = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         {d2_qx_in[k][0], d2_rx_in[k]} = div_step(d2_rx_ff[k-1],
                                                  d2_nx_ff[k-1][DIV_STAGES-k],
                                                  d2_den_ff[k-1]);
         {d2_qy_in[k][0], d2_ry_in[k]} = div_step(d2_ry_ff[k-1],
                                                  d2_ny_ff[k-1][DIV_STAGES-k],
                                                  d2_den_ff[k-1]);
         d2_qx_in[k][14:1] = d2_qx_ff[k-1][13:0];
         d2_qy_in[k][14:1] = d2_qy_ff[k-1][13:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_nx_ff[0]   <= prod_x;
         d2_ny_ff[0]   <= prod_y;
         d2_rx_ff[0]   <= prod_x[30:15];
         d2_ry_ff[0]   <= prod_y[30:15];
         d2_qx_ff[0]   <= '0;
         d2_qy_ff[0]   <= '0;
         d2_den_ff[0]  <= d1_r_ff[DIV_STAGES];
         d2_zone_ff[0] <= d1_zone_ff[DIV_STAGES];
         d2_s_ff[0]    <= d1_s_ff[DIV_STAGES];
         for (int k = 1; k <= DIV_STAGES; k++) begin
            d2_nx_ff[k]   <= d2_nx_ff[k-1];
            d2_ny_ff[k]   <= d2_ny_ff[k-1];
            d2_rx_ff[k]   <= d2_rx_in[k];
            d2_ry_ff[k]   <= d2_ry_in[k];
            d2_qx_ff[k]   <= d2_qx_in[k];
            d2_qy_ff[k]   <= d2_qy_in[k];
            d2_den_ff[k]  <= d2_den_ff[k-1];
            d2_zone_ff[k] <= d2_zone_ff[k-1];
            d2_s_ff[k]    <= d2_s_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            d2_v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         d2_v_ff[0] <= d1_v_ff[DIV_STAGES];
         for (int k = 1; k <= DIV_STAGES; k++) begin
            d2_v_ff[k] <= d2_v_ff[k-1];
         end
      end
   end

   // Final selection by zone with sign restore and saturation.
   always_comb begin
      case (d2_zone_ff[DIV_STAGES])
         ZONE_DEAD: out_data_in = '0;
         ZONE_BAND: begin
            out_data_in[15:0] = sat_axis(d2_s_ff[DIV_STAGES].x[15] ?
                                         -$signed({2'b00, d2_qx_ff[DIV_STAGES]}) :
                                         $signed({2'b00, d2_qx_ff[DIV_STAGES]}));
            out_data_in[31:16] = sat_axis(d2_s_ff[DIV_STAGES].y[15] ?
                                          -$signed({2'b00, d2_qy_ff[DIV_STAGES]}) :
                                          $signed({2'b00, d2_qy_ff[DIV_STAGES]}));
         end
         default: begin
            out_data_in[15:0]  = sat_axis($signed({d2_s_ff[DIV_STAGES].x[15],
                                                   d2_s_ff[DIV_STAGES].x}));
            out_data_in[31:16] = sat_axis($signed({d2_s_ff[DIV_STAGES].y[15],
                                                   d2_s_ff[DIV_STAGES].y}));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
         out_zone_ff <= d2_zone_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= d2_v_ff[DIV_STAGES];
      end
   end

endmodule

// ===== tb/sv/tb_radial_deadzone_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// Radial deadzone scaler testbench
// Drives stick samples through several deadzone and outer radius settings,
// predicts each filtered sample and zone, and compares them in order.
// ----------------------------------------------------------------------------
module tb_radial_deadzone_scaler_unit;
   import rdz_pkg::*;

   typedef struct packed {
      logic [1:0]  zone;
      logic [15:0] y;
      logic [15:0] x;
   } stick_result_type;

   class stick_scoreboard;
      int unsigned dead_radius = 0;
      int unsigned outer_radius = 32767;
      stick_result_type pending[$];
      int errors = 0;

      function automatic int unsigned floor_sqrt(longint unsigned v);
         longint unsigned res = 0;
         longint unsigned b = 64'h4000_0000;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function automatic logic [15:0] scale_axis(int a, longint r_out, longint r);
         longint mag;
         longint q;
         if (r == 0) return 16'd0;
         mag = (a < 0) ? -a : a;
         q = (mag * r_out) / r;
         if (a < 0) q = -q;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q[15:0];
      endfunction

      function void note_sample(logic [15:0] ix, logic [15:0] iy);
         stick_result_type e;
         int x;
         int y;
         longint unsigned r;
         longint unsigned r_out;
         x = $signed(ix);
         y = $signed(iy);
         if (dead_radius == 0) begin
            e.x = ix;
            e.y = iy;
            e.zone = ZONE_PASS;
         end else begin
            r = floor_sqrt(longint'(x) * x + longint'(y) * y);
            if (r < dead_radius) begin
               r_out = 0;
               e.zone = ZONE_DEAD;
            end else if (r < outer_radius) begin
               r_out = ((r - dead_radius) * outer_radius) / (outer_radius - dead_radius);
               e.zone = ZONE_BAND;
            end else begin
               r_out = r;
               e.zone = ZONE_PASS;
            end
            e.x = scale_axis(x, r_out, r);
            e.y = scale_axis(y, r_out, r);
         end
         pending = {pending, e};
      endfunction

      function void check_result(logic [31:0] data, logic [1:0] zone);
         stick_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h zone=%0d", $time, data[15:0],
                     data[31:16], zone);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[15:0] !== e.x) begin
            $display("%0t: out_x expected %h actual %h", $time, e.x, data[15:0]);
            errors++;
         end
         if (data[31:16] !== e.y) begin
            $display("%0t: out_y expected %h actual %h", $time, e.y, data[31:16]);
            errors++;
         end
         if (zone !== e.zone) begin
            $display("%0t: zone expected %0d actual %0d", $time, e.zone, zone);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_data = '0;

   stick_scoreboard board = new();
   int  cycle_count = 0;
   bit  calm = 0;
   int  hold_off = 0;

   radial_deadzone_scaler_unit DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 15);
      end
   end

   task automatic write_reg(logic [1:0] index, int unsigned value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= index;
      csr_data <= value[14:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_DEAD_RADIUS) board.dead_radius = value[14:0];
      else board.outer_radius = value[14:0];
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_sample(logic [15:0] x, logic [15:0] y);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_sample(x, y);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_axis();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(600)) - 16'd300;
         3: return 16'($urandom_range(2000)) - 16'd1000;
         default: return 16'($urandom);
      endcase
   endfunction

   int unsigned dz_set[6] = '{0, 1, 4000, 10000, 32767, 20000};
   int unsigned outer_set[6] = '{32767, 32767, 30000, 10000, 1, 0};
   logic [15:0] corner[7] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                             16'h1000, 16'hF000};

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_DEAD_RADIUS, dz_set[p]);
         write_reg(CSR_OUTER_RADIUS, outer_set[p]);
         if (p == 0 || p == 2) begin
            for (int i = 0; i < 7; i++) send_sample(corner[i], corner[(i * 3) % 7]);
            send_sample(16'h8000, 16'h8000);
            send_sample(16'h7FFF, 16'h0000);
         end
         if (p == 3) begin
            calm = 1;
            hold_off <= 200;
         end
         for (int i = 0; i < 200; i++) begin
            if (p == 4 && i == 100) calm = 0;
            if (p == 3 && i == 150) calm = 0;
            if ($urandom_range(9) == 0) send_sample(pick_axis(), 16'h0000);
            else send_sample(pick_axis(), pick_axis());
         end
         drain();
         if (p == 1) calm = 1;
      end
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rdz_pkg.sv
rtl/radial_deadzone_scaler_unit.sv
tb/sv/tb_radial_deadzone_scaler_unit.sv
